/* rtl/wrol_pkg.sv */
// wrol_pkg: shared types and constants for the write ring offset locator
// no dependencies; imported by wrol_ctrl, wrol_dp and write_ring_offset_locator
package wrol_pkg;

    localparam int SLOTS_DEF = 10;

    localparam int REQ_W    = 2;
    localparam int HANDLE_W = 32;
    localparam int SIZE_W   = 16;
    localparam int POS_W    = 20;
    localparam int CIDX_W   = 8;
    localparam int SLOT_W   = 4;

    localparam logic [REQ_W-1:0] REQ_ADD    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_FIND   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_SEEK   = 2'd2;
    localparam logic [REQ_W-1:0] REQ_STATUS = 2'd3;

    typedef struct packed {
        logic [REQ_W-1:0]    req_type;
        logic [HANDLE_W-1:0] new_handle;
        logic [SIZE_W-1:0]   new_size;
        logic [POS_W-1:0]    find_offset;
        logic [CIDX_W-1:0]   cmd_index;
        logic [SIZE_W-1:0]   cmd_offset;
    } wrol_in_t;

    typedef struct packed {
        logic                found;
        logic [SLOT_W-1:0]   slot_index;
        logic [HANDLE_W-1:0] found_handle;
        logic [SIZE_W-1:0]   byte_in_entry;
        logic [POS_W-1:0]    position;
        logic [POS_W-1:0]    total_bytes;
        logic                is_full;
    } wrol_out_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic step;
        logic emit;
    } wrol_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic walk_done;
        logic out_free;
    } wrol_stat_t;

endpackage

/* rtl/wrol_ctrl.sv */
// wrol_ctrl: sequencer for the write ring offset locator
// depends on wrol_pkg; drives wrol_dp through command/status structs
module wrol_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  wrol_pkg::wrol_stat_t stat,
    output wrol_pkg::wrol_cmd_t  cmd
);
    import wrol_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_WALK = 2'd1;
    localparam logic [1:0] ST_HOLD = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    assign s_ready  = (state_reg == ST_IDLE);
    assign cmd.load = s_valid && s_ready;
    assign cmd.step = (state_reg == ST_WALK);
    assign cmd.emit = (state_reg == ST_HOLD) && stat.out_free;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (cmd.load) begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK: begin
                if (stat.walk_done) begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (stat.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    a_walk_ends_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.step && stat.walk_done) |=> (state_reg == ST_HOLD))
        else $error("walk finished without moving to hold");

endmodule

/* rtl/wrol_dp.sv */
// wrol_dp: record file, ring pointers, walk registers and result register
// depends on wrol_pkg; sequenced by wrol_ctrl
module wrol_dp #(
    parameter int SLOTS = wrol_pkg::SLOTS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  wrol_pkg::wrol_cmd_t  cmd,
    output wrol_pkg::wrol_stat_t stat,
    input  wrol_pkg::wrol_in_t   s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output wrol_pkg::wrol_out_t  m_data
);
    import wrol_pkg::*;

    localparam int IDX_W = $clog2(SLOTS);
    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(SLOTS - 1);

    logic [HANDLE_W-1:0] handle_arr [SLOTS];
    logic [SIZE_W-1:0]   size_arr   [SLOTS];

    logic [IDX_W-1:0] wp_reg, wp_next;
    logic [IDX_W-1:0] op_reg, op_next;
    logic             full_reg;
    logic [POS_W-1:0] total_reg;

    wrol_in_t         req_reg;
    logic [IDX_W-1:0] slot_reg;
    logic [IDX_W-1:0] cnt_reg;
    logic [POS_W-1:0] rem_reg;
    logic [POS_W-1:0] acc_reg;

    logic                res_found_reg;
    logic [SLOT_W-1:0]   res_slot_reg;
    logic [HANDLE_W-1:0] res_handle_reg;
    logic [SIZE_W-1:0]   res_byte_reg;
    logic [POS_W-1:0]    res_pos_reg;

    logic      m_valid_reg;
    wrol_out_t m_data_reg;

    logic [HANDLE_W-1:0] rd_handle;
    logic [SIZE_W-1:0]   rd_size;
    logic                walk_done;
    logic                walk_found;
    logic                find_hit;
    logic                seek_in_range;
    logic                seek_at_idx;
    logic                seek_ok;
    logic [IDX_W-1:0]    slot_inc;

    assign rd_handle = handle_arr[slot_reg];
    assign rd_size   = size_arr[slot_reg];
    assign slot_inc  = (slot_reg == LAST_SLOT) ? '0 : slot_reg + 1'b1;

    assign find_hit      = {{(POS_W-SIZE_W){1'b0}}, rd_size} > rem_reg;
    assign seek_in_range = req_reg.cmd_index < CIDX_W'(SLOTS);
    assign seek_at_idx   = {{(CIDX_W-IDX_W){1'b0}}, cnt_reg} == req_reg.cmd_index;
    assign seek_ok       = (rd_handle != '0) && (rd_size > req_reg.cmd_offset);

    always_comb begin
        walk_done  = 1'b1;
        walk_found = 1'b0;
        case (req_reg.req_type)
            REQ_FIND: begin
                walk_done  = find_hit || (cnt_reg == LAST_SLOT);
                walk_found = find_hit;
            end
            REQ_SEEK: begin
                if (seek_in_range) begin
                    walk_done  = seek_at_idx;
                    walk_found = seek_at_idx && seek_ok;
                end
            end
            default: begin
                walk_done  = 1'b1;
                walk_found = 1'b0;
            end
        endcase
    end

    // ring pointer update for an add
    always_comb begin
        wp_next = (wp_reg == LAST_SLOT) ? '0 : wp_reg + 1'b1;
        op_next = op_reg;
        if (full_reg) begin
            op_next = (op_reg == LAST_SLOT) ? '0 : op_reg + 1'b1;
        end
    end

    assign stat.walk_done = walk_done;
    assign stat.out_free  = !m_valid_reg || m_ready;

    // record file, pointers and running total
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SLOTS; i++) begin
                handle_arr[i] <= '0;
                size_arr[i]   <= '0;
            end
            wp_reg    <= '0;
            op_reg    <= '0;
            full_reg  <= 1'b0;
            total_reg <= '0;
        end else if (cmd.step && (req_reg.req_type == REQ_ADD)) begin
            // slot_reg points at the write slot during an add
            handle_arr[wp_reg] <= req_reg.new_handle;
            size_arr[wp_reg]   <= req_reg.new_size;
            wp_reg    <= wp_next;
            op_reg    <= op_next;
            full_reg  <= (wp_next == op_next);
            total_reg <= total_reg - {{(POS_W-SIZE_W){1'b0}}, rd_size}
                         + {{(POS_W-SIZE_W){1'b0}}, req_reg.new_size};
        end
    end

    // walk registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_reg  <= s_data;
            slot_reg <= (s_data.req_type == REQ_ADD) ? wp_reg : op_reg;
            cnt_reg  <= '0;
            rem_reg  <= s_data.find_offset;
            acc_reg  <= '0;
        end else if (cmd.step) begin
            slot_reg <= slot_inc;
            cnt_reg  <= cnt_reg + 1'b1;
            rem_reg  <= rem_reg - {{(POS_W-SIZE_W){1'b0}}, rd_size};
            acc_reg  <= acc_reg + {{(POS_W-SIZE_W){1'b0}}, rd_size};
        end
    end

    // result staging, zero when nothing located
    always_ff @(posedge aclk) begin
        if (cmd.step && walk_done) begin
            res_found_reg  <= walk_found;
            res_slot_reg   <= '0;
            res_handle_reg <= '0;
            res_byte_reg   <= '0;
            res_pos_reg    <= '0;
            if (walk_found) begin
                res_slot_reg   <= SLOT_W'(slot_reg);
                res_handle_reg <= rd_handle;
                if (req_reg.req_type == REQ_SEEK) begin
                    res_byte_reg <= req_reg.cmd_offset;
                    res_pos_reg  <= acc_reg
                                    + {{(POS_W-SIZE_W){1'b0}}, req_reg.cmd_offset};
                end else begin
                    res_byte_reg <= rem_reg[SIZE_W-1:0];
                end
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_data_reg.found         <= res_found_reg;
            m_data_reg.slot_index    <= res_slot_reg;
            m_data_reg.found_handle  <= res_handle_reg;
            m_data_reg.byte_in_entry <= res_byte_reg;
            m_data_reg.position      <= res_pos_reg;
            m_data_reg.total_bytes   <= total_reg;
            m_data_reg.is_full       <= full_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_ptr_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (wp_reg <= LAST_SLOT) && (op_reg <= LAST_SLOT))
        else $error("ring pointer out of range");

    a_full_ptrs: assert property (@(posedge aclk) disable iff (!aresetn)
        full_reg |-> (wp_reg == op_reg))
        else $error("full ring with pointers apart");

    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_data_reg.found) |->
            (m_data_reg.slot_index == '0) && (m_data_reg.found_handle == '0)
            && (m_data_reg.byte_in_entry == '0) && (m_data_reg.position == '0))
        else $error("miss result carries nonzero fields");

endmodule

/* rtl/write_ring_offset_locator.sv */
// write_ring_offset_locator: top level, ring of write records with offset lookup
// depends on wrol_pkg, wrol_ctrl and wrol_dp
//
//   channel | ports                      | payload
//   --------+----------------------------+-----------------------------
//   request | s_valid, s_ready, s_data   | wrol_in_t (req_type ... cmd_offset)
//   result  | m_valid, m_ready, m_data   | wrol_out_t (found ... is_full)
//
// one request at a time: accept, walk, then hold until the output register is free and load it
// add and status visit one record; find visits 1 to SLOTS records; seek visits cmd_index+1
// (one when the index is out of range); the walk goes through the record file
// at one slot per cycle
// synchronous active-low reset clears all records, both pointers, the total and full flag
// a new request is taken while a result waits; the block holds its next result until taken
module write_ring_offset_locator #(
    parameter int SLOTS = wrol_pkg::SLOTS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  wrol_pkg::wrol_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output wrol_pkg::wrol_out_t m_data
);
    import wrol_pkg::*;

    wrol_cmd_t  cmd;
    wrol_stat_t stat;

    wrol_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    wrol_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .stat    (stat),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
